/* rtl/jsp_pkg.sv */
// shared types and status codes for the jpeg sof size parser
package jsp_pkg;

   // status codes carried on the result channel
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NO_SOI   = 3'd1;
   localparam logic [2:0] ST_NO_FF    = 3'd2;
   localparam logic [2:0] ST_EOI      = 3'd3;
   localparam logic [2:0] ST_SHORTLEN = 3'd4;
   localparam logic [2:0] ST_SOFLEN   = 3'd5;
   localparam logic [2:0] ST_TRUNC    = 3'd6;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [2:0]  status;
      logic [15:0] image_width;
      logic [15:0] image_height;
   } rsp_type;

   // one result leaving the parser toward the output buffer
   typedef struct packed {
      logic    valid;
      rsp_type payload;
   } result_type;

endpackage

/* rtl/jpeg_sof_size_parser_top.sv */
// top level of the jpeg sof size parser
// Scans a JPEG byte stream one byte per clock unless stalled and reports the
// image height and width from the first SOF segment, or an error status, as a
// single response per image. A request carries one byte plus a last-byte flag;
// one request is taken every cycle unless req_stall is high. The decision for a
// byte is made in the same cycle it is taken, and the response is registered
// into a two-entry output buffer (output register plus skid entry) for rsp_valid.
// Requests stall only when both buffer entries are occupied, so a response
// held by rsp_stall does not hold back the byte stream until a second one
// piles up behind it. Bytes after a decided outcome produce nothing; the byte
// flagged as last (with a truncation response if nothing was decided yet)
// rearms the parser for the next image.
module jpeg_sof_size_parser_top (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_stall,
   input  jsp_pkg::req_type req_payload,
   // response channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output jsp_pkg::rsp_type rsp_payload
);

   // request taken this cycle
   logic                req_accept;
   // parser decision for the accepted byte
   jsp_pkg::result_type result;
   // skid entry occupied
   logic                buf_full;

   assign req_stall  = buf_full;
   assign req_accept = req_valid && !buf_full;

   // marker walk and dimension capture
   jsp_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .req_data (req_payload),
      .result   (result)
   );

   // response register with skid entry
   jsp_rsp_buffer u_rsp_buffer (
      .clock       (clock),
      .reset       (reset),
      .result      (result),
      .full        (buf_full),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

/* rtl/jsp_parser.sv */
// byte-wise marker walk with state registers and same-cycle result decision
module jsp_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  jsp_pkg::req_type   req_data,
   output jsp_pkg::result_type result
);

   localparam logic [3:0] PH_SOI0   = 4'd0;
   localparam logic [3:0] PH_SOI1   = 4'd1;
   localparam logic [3:0] PH_PREFIX = 4'd2;
   localparam logic [3:0] PH_MARKER = 4'd3;
   localparam logic [3:0] PH_LENHI  = 4'd4;
   localparam logic [3:0] PH_LENLO  = 4'd5;
   localparam logic [3:0] PH_SKIP   = 4'd6;
   localparam logic [3:0] PH_SOF    = 4'd7;
   localparam logic [3:0] PH_DONE   = 4'd8;

   localparam logic [7:0] MK_PREFIX = 8'hFF;
   localparam logic [7:0] MK_SOI    = 8'hD8;
   localparam logic [7:0] MK_TEM    = 8'h01;
   localparam logic [7:0] MK_RST_LO = 8'hD0;
   localparam logic [7:0] MK_RST_HI = 8'hD7;
   localparam logic [7:0] MK_EOI    = 8'hD9;
   localparam logic [7:0] MK_SOF_LO = 8'hC0;
   localparam logic [7:0] MK_SOF_HI = 8'hCF;
   localparam logic [7:0] MK_DHT    = 8'hC4;
   localparam logic [7:0] MK_JPG    = 8'hC8;
   localparam logic [7:0] MK_DAC    = 8'hCC;
   localparam logic [15:0] SOF_MIN_LEN = 16'd7;
   localparam logic [15:0] SEG_MIN_LEN = 16'd2;

   logic [3:0]  phase_ff,  phase_in;
   logic [15:0] skip_ff,   skip_in;
   logic [7:0]  len_hi_ff, len_hi_in;
   logic        is_sof_ff, is_sof_in;
   logic [2:0]  idx_ff,    idx_in;
   logic [15:0] height_ff, height_in;
   logic [15:0] width_ff,  width_in;

   logic        emit;
   logic        emit_ok;
   logic [2:0]  emit_status;
   logic [7:0]  b;
   logic [15:0] seg;
   logic [15:0] seg_payload;
   logic [15:0] skip_dec;

   assign b           = req_data.data_byte;
   assign seg         = {len_hi_ff, b};
   assign seg_payload = seg - SEG_MIN_LEN;
   assign skip_dec    = skip_ff - 16'd1;

   always_comb begin
      phase_in    = phase_ff;
      skip_in     = skip_ff;
      len_hi_in   = len_hi_ff;
      is_sof_in   = is_sof_ff;
      idx_in      = idx_ff;
      height_in   = height_ff;
      width_in    = width_ff;
      emit        = 1'b0;
      emit_ok     = 1'b0;
      emit_status = jsp_pkg::ST_OK;

      unique case (phase_ff)
         PH_SOI0: begin
            if (b == MK_PREFIX) begin
               phase_in = PH_SOI1;
            end else begin
               emit = 1'b1; emit_status = jsp_pkg::ST_NO_SOI;
            end
         end
         PH_SOI1: begin
            if (b == MK_SOI) begin
               phase_in = PH_PREFIX;
            end else begin
               emit = 1'b1; emit_status = jsp_pkg::ST_NO_SOI;
            end
         end
         PH_PREFIX: begin
            if (b == MK_PREFIX) begin
               phase_in = PH_MARKER;
            end else begin
               emit = 1'b1; emit_status = jsp_pkg::ST_NO_FF;
            end
         end
         PH_MARKER: begin
            if (b == MK_PREFIX) begin
               // fill byte
            end else if (b == MK_TEM || (b >= MK_RST_LO && b <= MK_RST_HI)) begin
               phase_in = PH_PREFIX;
            end else if (b == MK_EOI) begin
               emit = 1'b1; emit_status = jsp_pkg::ST_EOI;
            end else begin
               is_sof_in = (b >= MK_SOF_LO) && (b <= MK_SOF_HI) && (b != MK_DHT)
                           && (b != MK_JPG) && (b != MK_DAC);
               phase_in  = PH_LENHI;
            end
         end
         PH_LENHI: begin
            len_hi_in = b;
            phase_in  = PH_LENLO;
         end
         PH_LENLO: begin
            if (seg < SEG_MIN_LEN) begin
               emit = 1'b1; emit_status = jsp_pkg::ST_SHORTLEN;
            end else if (is_sof_ff) begin
               if (seg < SOF_MIN_LEN) begin
                  emit = 1'b1; emit_status = jsp_pkg::ST_SOFLEN;
               end else begin
                  idx_in   = 3'd0;
                  phase_in = PH_SOF;
               end
            end else begin
               skip_in  = seg_payload;
               phase_in = (seg_payload == 16'd0) ? PH_PREFIX : PH_SKIP;
            end
         end
         PH_SKIP: begin
            skip_in = skip_dec;
            if (skip_dec == 16'd0) begin
               phase_in = PH_PREFIX;
            end
         end
         PH_SOF: begin
            // precision, height hi/lo, width hi/lo
            case (idx_ff)
               3'd1:    height_in = {b, 8'h00};
               3'd2:    height_in = {height_ff[15:8], b};
               3'd3:    width_in  = {b, 8'h00};
               3'd4:    width_in  = {width_ff[15:8], b};
               default: ;
            endcase
            if (idx_ff >= 3'd4) begin
               emit = 1'b1; emit_ok = 1'b1; emit_status = jsp_pkg::ST_OK;
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end
         default: ;
      endcase

      if (emit) begin
         phase_in = PH_DONE;
      end

      // final byte: report truncation if undecided, then rearm
      if (req_data.last_byte) begin
         if (!emit && phase_in != PH_DONE) begin
            emit = 1'b1; emit_status = jsp_pkg::ST_TRUNC;
         end
         phase_in  = PH_SOI0;
         skip_in   = 16'd0;
         len_hi_in = 8'd0;
         is_sof_in = 1'b0;
         idx_in    = 3'd0;
      end
   end

   always_comb begin
      result.valid                = accept && emit;
      result.payload.found        = emit_ok;
      result.payload.status       = emit_status;
      result.payload.image_width  = emit_ok ? width_in  : 16'd0;
      result.payload.image_height = emit_ok ? height_in : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SOI0;
         skip_ff   <= 16'd0;
         len_hi_ff <= 8'd0;
         is_sof_ff <= 1'b0;
         idx_ff    <= 3'd0;
         height_ff <= 16'd0;
         width_ff  <= 16'd0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         skip_ff   <= skip_in;
         len_hi_ff <= len_hi_in;
         is_sof_ff <= is_sof_in;
         idx_ff    <= idx_in;
         height_ff <= req_data.last_byte ? 16'd0 : height_in;
         width_ff  <= req_data.last_byte ? 16'd0 : width_in;
      end
   end

endmodule

/* rtl/jsp_rsp_buffer.sv */
// two-entry result buffer: output register plus skid entry
module jsp_rsp_buffer (
   input  logic                clock,
   input  logic                reset,
   input  jsp_pkg::result_type result,
   output logic                full,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output jsp_pkg::rsp_type    rsp_payload
);

   logic             main_v_ff, main_v_in;
   logic             skid_v_ff, skid_v_in;
   jsp_pkg::rsp_type main_ff,  main_in;
   jsp_pkg::rsp_type skid_ff,  skid_in;
   logic             out_fire;

   assign out_fire = main_v_ff && !rsp_stall;

   always_comb begin
      main_v_in = main_v_ff;
      main_in   = main_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (!main_v_ff || out_fire) begin
         if (skid_v_ff) begin
            main_v_in = 1'b1;
            main_in   = skid_ff;
            skid_v_in = result.valid;
            skid_in   = result.payload;
         end else begin
            main_v_in = result.valid;
            main_in   = result.payload;
         end
      end else if (result.valid) begin
         skid_v_in = 1'b1;
         skid_in   = result.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         main_v_ff <= main_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full        = skid_v_ff;
   assign rsp_valid   = main_v_ff;
   assign rsp_payload = main_ff;

endmodule

/* rtl/jsp_checker.sv */
// port-level checker for the jpeg sof size parser, bound to the top level
module jsp_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input jsp_pkg::rsp_type rsp_payload
);

   // held response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // held response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_payload))
      else $error("response payload changed while stalled");

   // success always carries the ok status
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.found |-> rsp_payload.status == jsp_pkg::ST_OK)
      else $error("found set with error status");

   // failures report zero dimensions and an error status
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.found |->
         rsp_payload.image_width == 16'd0 && rsp_payload.image_height == 16'd0
         && rsp_payload.status != jsp_pkg::ST_OK)
      else $error("failure response with dimensions or ok status");

   // no status beyond truncation
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.status <= jsp_pkg::ST_TRUNC)
      else $error("undefined status code");

endmodule

bind jpeg_sof_size_parser_top jsp_checker u_jsp_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
